// ----- rtl/assert_macros.svh -----
// assert_macros.svh: concurrent assertion macros for the LRU frame replacer.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check a consequence in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lfr_pkg.sv -----
`timescale 1ns / 1ps
// lfr_pkg: widths, operation codes and shared types of the LRU frame replacer.
// No dependencies.
package lfr_pkg;

   localparam int FRAME_W = 6;
   localparam int COUNT_W = 7;
   localparam int MAX_IDS = 64;

   localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      FUNC_VICTIM = 2'd0,
      FUNC_PIN    = 2'd1,
      FUNC_UNPIN  = 2'd2
   } func_type;

   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic      en;
      frame_type addr;
      frame_type data;
   } link_wr_type;

   typedef struct packed {
      logic      done_res;
      frame_type victim_frame;
      count_type tracked_count;
   } result_type;

endpackage

// ----- rtl/lfr_req_if.sv -----
`timescale 1ns / 1ps
// lfr_req_if: request channel (valid/ready plus operation beat).
// Depends on lfr_pkg.
interface lfr_req_if import lfr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] func;
   frame_type  frame_no;

   modport source (output valid, func, frame_no, input ready);
   modport sink   (input valid, func, frame_no, output ready);
endinterface

// ----- rtl/lfr_rsp_if.sv -----
`timescale 1ns / 1ps
// lfr_rsp_if: response channel (valid/ready plus result beat).
// Depends on lfr_pkg.
interface lfr_rsp_if import lfr_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      done_res;
   frame_type victim_frame;
   count_type tracked_count;

   modport source (output valid, done_res, victim_frame, tracked_count, input ready);
   modport sink   (input valid, done_res, victim_frame, tracked_count, output ready);
endinterface

// ----- rtl/lfr_link_ram.sv -----
`timescale 1ns / 1ps
// lfr_link_ram: one-write one-read link memory with registered read data.
// A write and read to the same entry in one cycle return the new data. Depends on lfr_pkg.
module lfr_link_ram import lfr_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  link_wr_type wr,
   input  logic        rd_en,
   input  frame_type   rd_addr,
   output frame_type   rd_data_ff
);

   localparam int IDX_W = $clog2(DEPTH);

   frame_type        mem [DEPTH];
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   assign wr_idx = IDX_W'(wr.addr);
   assign rd_idx = IDX_W'(rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr_idx == rd_idx) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

endmodule

// ----- rtl/lfr_list_core.sv -----
`timescale 1ns / 1ps
// lfr_list_core: membership marks, list ends and count; decodes one operation
// and produces the link writes and the result. Depends on lfr_pkg, assert_macros.svh.
`include "assert_macros.svh"
module lfr_list_core import lfr_pkg::*; #(
   parameter int NUM_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  func_type    func,
   input  frame_type   frame_no,
   input  count_type   capacity,
   input  frame_type   rd_next,
   input  frame_type   rd_prev,
   output link_wr_type next_wr,
   output link_wr_type prev_wr,
   output frame_type   oldest_in,
   output result_type  result
);

   localparam int DEPTH = (NUM_FRAMES < MAX_IDS) ? NUM_FRAMES : MAX_IDS;
   localparam int IDX_W = $clog2(DEPTH);

   logic [DEPTH-1:0] present_ff;
   logic [DEPTH-1:0] present_in;
   frame_type        oldest_ff;
   frame_type        newest_ff;
   frame_type        newest_in;
   count_type        count_ff;
   count_type        count_in;
   logic [IDX_W-1:0] idx;
   logic             fid_ok;
   logic             hit;
   logic             has_any;
   logic             done;
   frame_type        victim;

   assign idx     = IDX_W'(frame_no);
   assign fid_ok  = int'(frame_no) < NUM_FRAMES;
   assign hit     = fid_ok && present_ff[idx];
   assign has_any = count_ff != '0;

   always_comb begin
      present_in = present_ff;
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      count_in   = count_ff;
      next_wr    = '0;
      prev_wr    = '0;
      done       = 1'b0;
      victim     = '0;
      if (advance) begin
         unique case (func)
            FUNC_VICTIM: begin
               if (has_any) begin
                  done                            = 1'b1;
                  victim                          = oldest_ff;
                  present_in[IDX_W'(oldest_ff)]   = 1'b0;
                  oldest_in                       = rd_next;
                  count_in                        = count_ff - COUNT_W'(1);
               end
            end
            FUNC_PIN: begin
               if (hit) begin
                  done            = 1'b1;
                  present_in[idx] = 1'b0;
                  count_in        = count_ff - COUNT_W'(1);
                  if (frame_no == oldest_ff) begin
                     oldest_in = rd_next;
                  end else begin
                     next_wr = '{en: 1'b1, addr: rd_prev, data: rd_next};
                  end
                  if (frame_no == newest_ff) begin
                     newest_in = rd_prev;
                  end else begin
                     prev_wr = '{en: 1'b1, addr: rd_next, data: rd_prev};
                  end
               end
            end
            FUNC_UNPIN: begin
               if (fid_ok && count_ff < capacity && !present_ff[idx]) begin
                  done            = 1'b1;
                  present_in[idx] = 1'b1;
                  count_in        = count_ff + COUNT_W'(1);
                  newest_in       = frame_no;
                  if (!has_any) begin
                     oldest_in = frame_no;
                  end else begin
                     next_wr = '{en: 1'b1, addr: newest_ff, data: frame_no};
                     prev_wr = '{en: 1'b1, addr: frame_no, data: newest_ff};
                  end
               end
            end
            default: begin
            end
         endcase
         // empty list parks both ends at zero
         if (count_in == '0) begin
            oldest_in = '0;
            newest_in = '0;
         end
      end
   end

   assign result = '{done_res: done, victim_frame: victim, tracked_count: count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         oldest_ff  <= '0;
         newest_ff  <= '0;
         count_ff   <= '0;
      end else begin
         present_ff <= present_in;
         oldest_ff  <= oldest_in;
         newest_ff  <= newest_in;
         count_ff   <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_marks, $countones(present_ff) == int'(count_ff), "count differs from marks")
   `ASSERT_IMPLY(a_empty_ends, count_ff == '0, oldest_ff == '0 && newest_ff == '0, "empty list ends not zero")
   `ASSERT_IMPLY(a_ends_tracked, count_ff != '0, present_ff[IDX_W'(oldest_ff)] && present_ff[IDX_W'(newest_ff)], "list end not tracked")

endmodule

// ----- rtl/lru_frame_replacer.sv -----
`timescale 1ns / 1ps
// lru_frame_replacer: LRU list of evictable frames; victim, pin and unpin requests.
// A request beat is registered into s1 together with its link RAM reads, then into the result register.
// Throughput: one request per cycle when not back-pressured; the link RAMs take one read and one write each cycle.
// Reset (synchronous): clears marks, list ends and count, sets capacity to 64.
// Link RAM contents are not cleared.
`include "assert_macros.svh"
module lru_frame_replacer import lfr_pkg::*; #(
   parameter int NUM_FRAMES = 64
) (
   input  logic      clock,
   input  logic      reset,
   lfr_req_if.sink   req_chan,
   lfr_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  count_type csr_wr_data
);

   localparam int DEPTH = (NUM_FRAMES < MAX_IDS) ? NUM_FRAMES : MAX_IDS;

   count_type   capacity_ff;
   logic        s1_valid_ff;
   logic        s1_valid_in;
   func_type    s1_func_ff;
   frame_type   s1_frame_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_data_ff;
   result_type  result;
   logic        advance;
   logic        accept;
   frame_type   oldest_in;
   frame_type   next_raddr;
   frame_type   rd_next;
   frame_type   rd_prev;
   link_wr_type next_wr;
   link_wr_type prev_wr;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign next_raddr     = (func_type'(req_chan.func) == FUNC_VICTIM) ? oldest_in
                                                                        : req_chan.frame_no;
   assign s1_valid_in    = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   lfr_link_ram #(.DEPTH(DEPTH)) u_next_ram (
      .clock      (clock),
      .wr         (next_wr),
      .rd_en      (accept),
      .rd_addr    (next_raddr),
      .rd_data_ff (rd_next)
   );

   lfr_link_ram #(.DEPTH(DEPTH)) u_prev_ram (
      .clock      (clock),
      .wr         (prev_wr),
      .rd_en      (accept),
      .rd_addr    (req_chan.frame_no),
      .rd_data_ff (rd_prev)
   );

   lfr_list_core #(.NUM_FRAMES(NUM_FRAMES)) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .func      (s1_func_ff),
      .frame_no  (s1_frame_ff),
      .capacity  (capacity_ff),
      .rd_next   (rd_next),
      .rd_prev   (rd_prev),
      .next_wr   (next_wr),
      .prev_wr   (prev_wr),
      .oldest_in (oldest_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= func_type'(req_chan.func);
         s1_frame_ff <= req_chan.frame_no;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.done_res      = rsp_data_ff.done_res;
   assign rsp_chan.victim_frame  = rsp_data_ff.victim_frame;
   assign rsp_chan.tracked_count = rsp_data_ff.tracked_count;

   `ASSERT_IMPLY(a_stall_cause, s1_valid_ff && !advance, rsp_valid_ff && !rsp_chan.ready, "stage held without back-pressure")
   `ASSERT_NEXT(a_commit_loads_rsp, advance, rsp_valid_ff, "committed beat not presented")

endmodule

// ----- sim/lru_list_monitor.sv -----
`timescale 1ns / 1ps
// lru_list_monitor: watches the request, result and capacity ports of lru_frame_replacer,
// keeps its own copy of the LRU list and compares every result beat with the prediction.
// Depends on lfr_pkg, lfr_req_if and lfr_rsp_if.
module lru_list_monitor import lfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lfr_req_if        req_mon,
   lfr_rsp_if        rsp_mon,
   input  logic      csr_wr_en,
   input  count_type csr_wr_data,
   output int        fail_count,
   output int        pending
);

   localparam int DUE_W = 3;
   localparam int DUE_DEPTH = 1 << DUE_W;

   logic             tracked [MAX_IDS];
   frame_type        nxt [MAX_IDS];
   frame_type        prv [MAX_IDS];
   frame_type        oldest_id;
   frame_type        newest_id;
   count_type        num_tracked;
   count_type        capacity;
   result_type       due_ring [DUE_DEPTH];
   logic [DUE_W-1:0] due_rd;
   logic [DUE_W-1:0] due_wr;
   int               due_cnt;
   int               errs;

   function automatic void unlink(frame_type f);
      frame_type p;
      frame_type n;
      p = prv[f];
      n = nxt[f];
      if (f == oldest_id) oldest_id = n;
      else nxt[p] = n;
      if (f == newest_id) newest_id = p;
      else prv[n] = p;
      tracked[f] = 1'b0;
      num_tracked = num_tracked - 1'b1;
      if (num_tracked == 0) begin
         oldest_id = '0;
         newest_id = '0;
      end
   endfunction

   function automatic result_type lru_update(logic [1:0] op, frame_type fid);
      result_type r;
      frame_type  f;
      r = '0;
      case (op)
         FUNC_VICTIM: begin
            if (num_tracked != 0) begin
               f = oldest_id;
               unlink(f);
               r.done_res = 1'b1;
               r.victim_frame = f;
            end
         end
         FUNC_PIN: begin
            if (tracked[fid]) begin
               unlink(fid);
               r.done_res = 1'b1;
            end
         end
         FUNC_UNPIN: begin
            if (num_tracked < capacity && !tracked[fid]) begin
               if (num_tracked == 0) oldest_id = fid;
               else begin
                  nxt[newest_id] = fid;
                  prv[fid] = newest_id;
               end
               newest_id = fid;
               nxt[fid] = '0;
               tracked[fid] = 1'b1;
               num_tracked = num_tracked + 1'b1;
               r.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      r.tracked_count = num_tracked;
      return r;
   endfunction

   function automatic void flag_error(string msg);
      errs++;
      if (errs <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      result_type pred;
      if (reset) begin
         for (int i = 0; i < MAX_IDS; i++) begin
            tracked[i] = 1'b0;
            nxt[i] = '0;
            prv[i] = '0;
         end
         oldest_id = '0;
         newest_id = '0;
         num_tracked = '0;
         capacity = CAP_RESET;
         due_rd = '0;
         due_wr = '0;
         due_cnt = 0;
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.done_res = rsp_mon.done_res;
            got.victim_frame = rsp_mon.victim_frame;
            got.tracked_count = rsp_mon.tracked_count;
            if (due_cnt == 0) begin
               flag_error($sformatf("unexpected result beat done=%0d victim=%0d count=%0d",
                  got.done_res, got.victim_frame, got.tracked_count));
            end else begin
               want = due_ring[due_rd];
               due_rd = due_rd + DUE_W'(1);
               due_cnt--;
               if (got.done_res !== want.done_res || got.victim_frame !== want.victim_frame ||
                   got.tracked_count !== want.tracked_count) begin
                  flag_error($sformatf(
                     "result: expected done=%0d victim=%0d count=%0d, got done=%0d victim=%0d count=%0d",
                     want.done_res, want.victim_frame, want.tracked_count,
                     got.done_res, got.victim_frame, got.tracked_count));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pred = lru_update(req_mon.func, req_mon.frame_no);
            if (due_cnt == DUE_DEPTH) begin
               flag_error("more request beats in flight than the block can hold");
            end else begin
               due_ring[due_wr] = pred;
               due_wr = due_wr + DUE_W'(1);
               due_cnt++;
            end
         end
      end
      pending <= due_cnt;
      fail_count <= errs;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives victim, pin, unpin and unused-code beats and capacity writes into lru_frame_replacer
// with random gaps and stalls, and gives the verdict from lru_list_monitor's failure and pending counts.
// Depends on lfr_pkg, lfr_req_if, lfr_rsp_if, lru_list_monitor and lru_frame_replacer.
module tb_top;
   import lfr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int PHASES = 8;
   localparam int PHASE_BEATS = 104;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   count_type csr_wr_data;
   int        fail_count;
   int        pending;
   bit        src_gappy;
   bit        rsp_gappy;
   bit        stall_go;

   lfr_req_if req_chan ();
   lfr_rsp_if rsp_chan ();

   lru_frame_replacer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lru_list_monitor u_mon (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   task automatic send_op(logic [1:0] op, frame_type fid);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.func <= op;
      req_chan.frame_no <= fid;
      do @(posedge clock); while (!req_chan.ready);
      gap = src_gappy ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and wait until every result beat is back
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(count_type value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random ready, plus one long hold-off on request
   initial begin : rsp_side
      int hold;
      int burst;
      bit stall_seen;
      hold = 0;
      burst = 0;
      stall_seen = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_go && !stall_seen) begin
            stall_seen = 1'b1;
            hold = LONG_HOLD;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else if (burst > 0 || !rsp_gappy) begin
            rsp_chan.ready <= 1'b1;
            if (burst > 0) burst--;
         end else begin
            hold = pick_gap();
            burst = $urandom_range(0, 15);
            if (hold > 0) begin
               rsp_chan.ready <= 1'b0;
               hold--;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) quiet = 0;
         else quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int         vic_pct;
      int         pin_pct;
      int         id_max;
      int         roll;
      logic [1:0] op;
      count_type  caps [PHASES];

      req_chan.valid = 1'b0;
      req_chan.func = FUNC_VICTIM;
      req_chan.frame_no = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      src_gappy = 1'b1;
      rsp_gappy = 1'b1;
      stall_go = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, middle and newest removal, duplicates, unused code
      send_op(FUNC_VICTIM, 6'd63);
      send_op(FUNC_PIN, 6'd0);
      send_op(FUNC_UNPIN, 6'd0);
      send_op(FUNC_UNPIN, 6'd63);
      send_op(FUNC_UNPIN, 6'd63);
      send_op(FUNC_UNPIN, 6'd21);
      send_op(FUNC_UNUSED, 6'd42);
      send_op(FUNC_PIN, 6'd63);
      send_op(FUNC_PIN, 6'd21);
      send_op(FUNC_UNPIN, 6'd42);
      send_op(FUNC_UNPIN, 6'd5);
      send_op(FUNC_VICTIM, 6'd0);
      send_op(FUNC_VICTIM, 6'd63);
      send_op(FUNC_VICTIM, 6'd0);
      send_op(FUNC_VICTIM, 6'd0);
      send_op(FUNC_PIN, 6'd0);

      // directed: capacity limit, capacity below count, zero capacity
      set_capacity(7'd2);
      send_op(FUNC_UNPIN, 6'd7);
      send_op(FUNC_UNPIN, 6'd9);
      send_op(FUNC_UNPIN, 6'd11);
      set_capacity(7'd1);
      send_op(FUNC_UNPIN, 6'd11);
      send_op(FUNC_PIN, 6'd9);
      send_op(FUNC_UNPIN, 6'd11);
      send_op(FUNC_VICTIM, 6'd0);
      set_capacity(7'd0);
      send_op(FUNC_UNPIN, 6'd3);

      caps[0] = 7'd64;
      caps[1] = 7'd1;
      caps[2] = 7'd8;
      caps[3] = count_type'($urandom_range(0, 64));
      caps[4] = 7'd64;
      caps[5] = 7'd3;
      caps[6] = 7'd63;
      caps[7] = count_type'($urandom_range(0, 64));

      for (int p = 0; p < PHASES; p++) begin
         set_capacity(caps[p]);
         case (p % 3)
            0: begin vic_pct = 12; pin_pct = 30; end
            1: begin vic_pct = 28; pin_pct = 52; end
            default: begin vic_pct = 42; pin_pct = 72; end
         endcase
         case (p % 4)
            0: id_max = 63;
            1: id_max = 7;
            2: id_max = 15;
            default: id_max = 63;
         endcase
         src_gappy = (p % 4) != 1 && p != 4 && p != 6;
         rsp_gappy = (p % 4) != 2 && p != 6;
         // long receiver hold-off while the sender keeps offering beats
         if (p == 4) stall_go = 1'b1;
         for (int k = 0; k < PHASE_BEATS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < vic_pct) op = FUNC_VICTIM;
            else if (roll < pin_pct) op = FUNC_PIN;
            else if (roll < pin_pct + 3) op = FUNC_UNUSED;
            else op = FUNC_UNPIN;
            send_op(op, frame_type'($urandom_range(0, id_max)));
         end
      end

      settle();
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lfr_pkg.sv
rtl/lfr_req_if.sv
rtl/lfr_rsp_if.sv
rtl/lfr_link_ram.sv
rtl/lfr_list_core.sv
rtl/lru_frame_replacer.sv
sim/lru_list_monitor.sv
sim/tb_top.sv
